// ===== src/tvfm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_pkg
// Shared types, codes and constants of the track to vertex first-match block,
// including the elaboration-time quarter-wave sine generator.
// ---------------------------------------------------------------------------
package tvfm_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int SINE_DEPTH_DEF   = 1024;

   localparam int COORD_W = 24;
   localparam int THETA_W = 16;
   localparam int CUT_W   = 23;
   localparam int INDEX_W = 6;
   localparam int SINE_W  = 16;
   localparam int ZT_W    = 25;
   localparam int ADZ_W   = 25;
   localparam int PROD_W  = ADZ_W + SINE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_MATCH  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRANSVERSE_CUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CUT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z0SIN_CUT      = 2'd2;

   localparam logic signed [COORD_W-1:0] TRANSVERSE_CUT_RESET = 24'sh7FFFFF;
   localparam logic [CUT_W-1:0]          CUT_RESET            = 23'h7FFFFF;

   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

   typedef struct packed {
      logic [1:0]                  mode;
      logic signed [COORD_W-1:0]   vertex_z;
      logic signed [COORD_W-1:0]   track_d0;
      logic signed [COORD_W-1:0]   track_z0;
      logic signed [COORD_W-1:0]   track_vz;
      logic [THETA_W-1:0]          track_theta;
   } req_data_type;

   typedef struct packed {
      logic               matched;
      logic [INDEX_W-1:0] vertex_index;
   } rsp_data_type;

   typedef struct packed {
      logic done;
      logic hit;
   } scan_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } tvfm_state_type;

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[123:60];
   endfunction

   // Q1.15 sine of pi/2 * k / depth via Taylor series in Q60
   function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] k,
                                                     input logic [63:0] depth);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] n;
      logic [63:0] v;
      logic        sub;
      q    = udiv64(HALF_PI_Q60, depth);
      r    = HALF_PI_Q60 - q * depth;
      x    = q * k + udiv64(r * k, depth);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      n    = 64'd1;
      sub  = 1'b1;
      for (int j = 0; j < 30; j++) begin
         if (term != 64'd0) begin
            term = udiv64(mul_q60(term, x2), (n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
            sum  = sub ? sum - term : sum + term;
            sub  = !sub;
         end
      end
      v = (sum + (64'd1 << 44)) >> 45;
      return (v > 64'd32767) ? 16'd32767 : v[SINE_W-1:0];
   endfunction

endpackage

// ===== src/track_vertex_first_match_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// track_vertex_first_match_top
// Track to vertex association, first match: vertex table upkeep, transverse
// cut, and an in-order scan of stored vertex z positions.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  tvfm_pkg::req_data_type
//  rsp      out        rsp_valid/rsp_ready  tvfm_pkg::rsp_data_type
//  csr      in         csr_we               csr_index, csr_wdata
//
//  Clear, append and unused mode items give no result.
//  A track scans the memory one vertex per cycle, in order, and stops early
//  on a match; with an empty table no vertex is read, and a track whose d0
//  fails the cut skips the scan.
//  Reset is synchronous: the fill count is zeroed, memory contents are left
//  as they are (entries past the count are never read), no clearing pass.
//  A result waits in the output register; a new item is taken once the
//  result is loaded there, while the previous one may still be pending.
// ---------------------------------------------------------------------------
module track_vertex_first_match_top #(
   parameter int MAX_VERTICES     = tvfm_pkg::MAX_VERTICES_DEF,
   parameter int SINE_TABLE_DEPTH = tvfm_pkg::SINE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tvfm_pkg::req_data_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tvfm_pkg::rsp_data_type         rsp_data,
   input  logic                           csr_we,
   input  logic [tvfm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tvfm_pkg::COORD_W-1:0]   csr_wdata
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   tvfm_pkg::tvfm_state_type state_ff, state_in;

   logic signed [tvfm_pkg::COORD_W-1:0] tcut_ff;
   logic [tvfm_pkg::CUT_W-1:0]          lcut_ff;
   logic [tvfm_pkg::CUT_W-1:0]          zcut_ff;
   logic signed [tvfm_pkg::ZT_W-1:0]    zt_ff;
   logic                                res_matched_ff;
   logic [tvfm_pkg::INDEX_W-1:0]        res_index_ff;
   tvfm_pkg::rsp_data_type              rsp_ff;
   logic                                rsp_valid_ff;

   logic                                accept;
   logic                                is_track;
   logic                                d0_fail;
   logic                                start_scan;
   logic                                do_clear;
   logic                                do_append;
   logic                                load_rsp;

   tvfm_pkg::scan_stat_type             stat;
   logic [AW-1:0]                       hit_index;
   logic                                rd_en;
   logic [AW-1:0]                       rd_addr;
   logic signed [tvfm_pkg::COORD_W-1:0] rd_data;
   logic [CW-1:0]                       count;
   logic [tvfm_pkg::SINE_W-1:0]         sine;

   assign accept   = req_valid && req_ready;
   assign is_track = req_data.mode == tvfm_pkg::MODE_MATCH;
   assign d0_fail  = req_data.track_d0 > tcut_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tvfm_pkg::ST_IDLE: begin
            if (accept && is_track) begin
               state_in = d0_fail ? tvfm_pkg::ST_RESULT : tvfm_pkg::ST_SCAN;
            end
         end
         tvfm_pkg::ST_SCAN: begin
            if (stat.done) begin
               state_in = tvfm_pkg::ST_RESULT;
            end
         end
         tvfm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = tvfm_pkg::ST_IDLE;
            end
         end
         default: state_in = tvfm_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready  = 1'b0;
      load_rsp   = 1'b0;
      start_scan = 1'b0;
      do_clear   = 1'b0;
      do_append  = 1'b0;
      case (state_ff)
         tvfm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            start_scan = req_valid && is_track && !d0_fail;
            do_clear   = req_valid && (req_data.mode == tvfm_pkg::MODE_CLEAR);
            do_append  = req_valid && (req_data.mode == tvfm_pkg::MODE_APPEND);
         end
         tvfm_pkg::ST_SCAN: begin
         end
         tvfm_pkg::ST_RESULT: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvfm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tcut_ff      <= tvfm_pkg::TRANSVERSE_CUT_RESET;
         lcut_ff      <= tvfm_pkg::CUT_RESET;
         zcut_ff      <= tvfm_pkg::CUT_RESET;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               tvfm_pkg::CSR_TRANSVERSE_CUT: tcut_ff <= csr_wdata;
               tvfm_pkg::CSR_LONG_CUT:       lcut_ff <= csr_wdata[tvfm_pkg::CUT_W-1:0];
               tvfm_pkg::CSR_Z0SIN_CUT:      zcut_ff <= csr_wdata[tvfm_pkg::CUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_track) begin
         zt_ff          <= tvfm_pkg::ZT_W'(req_data.track_z0)
                         + tvfm_pkg::ZT_W'(req_data.track_vz);
         res_matched_ff <= 1'b0;
         res_index_ff   <= '0;
      end else if (stat.hit) begin
         res_matched_ff <= 1'b1;
         res_index_ff   <= tvfm_pkg::INDEX_W'(hit_index);
      end
      if (load_rsp) begin
         rsp_ff.matched      <= res_matched_ff;
         rsp_ff.vertex_index <= res_index_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tvfm_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock (clock),
      .load  (accept && is_track),
      .theta (req_data.track_theta),
      .sine  (sine)
   );

   tvfm_vertex_store #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_vertex_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (do_clear),
      .append  (do_append),
      .wr_data (req_data.vertex_z),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .count   (count)
   );

   tvfm_match_pipe #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_match_pipe (
      .clock     (clock),
      .reset     (reset),
      .start     (start_scan),
      .count     (count),
      .zt        (zt_ff),
      .sine      (sine),
      .long_cut  (lcut_ff),
      .z0sin_cut (zcut_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .stat      (stat),
      .hit_index (hit_index)
   );

endmodule

// ===== src/tvfm_sine_rom.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_sine_rom
// Folds the polar angle into the first quadrant, rounds it to a table index
// and reads sin(theta) in Q1.15 from a registered quarter-wave ROM.
// ---------------------------------------------------------------------------
module tvfm_sine_rom #(
   parameter int SINE_TABLE_DEPTH = tvfm_pkg::SINE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [tvfm_pkg::THETA_W-1:0] theta,
   output logic [tvfm_pkg::SINE_W-1:0]  sine
);

   localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PW = tvfm_pkg::THETA_W + KW + 1;

   typedef logic [tvfm_pkg::SINE_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   function automatic sine_rom_type build_rom();
      sine_rom_type rom;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         rom[k] = tvfm_pkg::sine_entry(64'(k), 64'(SINE_TABLE_DEPTH));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_rom();

   logic [tvfm_pkg::THETA_W-1:0] fold_angle;
   logic [PW-1:0]                scaled;
   logic [PW-1:0]                index_raw;
   logic [KW-1:0]                index_in;
   logic [KW-1:0]                index_ff;
   logic [tvfm_pkg::SINE_W-1:0]  sine_ff;

   // angles past pi/2 mirror about it
   assign fold_angle = theta[tvfm_pkg::THETA_W-1]
                     ? tvfm_pkg::THETA_W'(17'h10000 - {1'b0, theta}) : theta;
   assign scaled     = PW'(fold_angle) * PW'(SINE_TABLE_DEPTH);
   assign index_raw  = (scaled + PW'(32'd16384)) >> 15;
   assign index_in   = (index_raw > PW'(SINE_TABLE_DEPTH))
                     ? KW'(SINE_TABLE_DEPTH) : KW'(index_raw);

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= index_in;
      end
      sine_ff <= SINE_ROM[index_ff];
   end

   assign sine = sine_ff;

endmodule

// ===== src/tvfm_vertex_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_vertex_store
// Vertex z memory with its fill count: clear, append at the fill point, and
// one registered read per cycle for the scan.
// ---------------------------------------------------------------------------
module tvfm_vertex_store #(
   parameter int MAX_VERTICES = tvfm_pkg::MAX_VERTICES_DEF,
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                append,
   input  logic signed [tvfm_pkg::COORD_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [tvfm_pkg::COORD_W-1:0] rd_data,
   output logic [CW-1:0]                       count
);

   logic signed [tvfm_pkg::COORD_W-1:0] mem [MAX_VERTICES];
   logic signed [tvfm_pkg::COORD_W-1:0] rd_data_ff;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic                                room;

   assign room = count_ff < CW'(MAX_VERTICES);

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (append && room) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (append && room) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule

// ===== src/tvfm_match_pipe.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_match_pipe
// Scans the vertex memory in order, one read per cycle, through a three
// stage compare pipe; stops at the first vertex that passes both cuts.
// ---------------------------------------------------------------------------
module tvfm_match_pipe #(
   parameter int MAX_VERTICES = tvfm_pkg::MAX_VERTICES_DEF,
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [CW-1:0]                       count,
   input  logic signed [tvfm_pkg::ZT_W-1:0]    zt,
   input  logic [tvfm_pkg::SINE_W-1:0]         sine,
   input  logic [tvfm_pkg::CUT_W-1:0]          long_cut,
   input  logic [tvfm_pkg::CUT_W-1:0]          z0sin_cut,
   output logic                                rd_en,
   output logic [AW-1:0]                       rd_addr,
   input  logic signed [tvfm_pkg::COORD_W-1:0] rd_data,
   output tvfm_pkg::scan_stat_type             stat,
   output logic [AW-1:0]                       hit_index
);

   localparam int ADZ_W  = tvfm_pkg::ADZ_W;
   localparam int PROD_W = tvfm_pkg::PROD_W;
   localparam int DZ_W   = tvfm_pkg::ZT_W + 1;

   logic              scanning_ff;
   logic              scanning_in;
   logic [CW-1:0]     issue_addr_ff;
   logic [CW-1:0]     issue_addr_in;
   logic              v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]     idx1_ff, idx2_ff, idx3_ff;
   logic [ADZ_W-1:0]  adz2_ff;
   logic [PROD_W-1:0] prod3_ff;
   logic              lfail3_ff;
   logic signed [DZ_W-1:0] dz;
   logic [ADZ_W-1:0]  adz_in;
   logic              issue;
   logic              hit;
   logic              drained;
   logic              done;

   assign hit     = v3_ff && !lfail3_ff
                 && (prod3_ff <= (PROD_W'(z0sin_cut) << 15));
   assign issue   = scanning_ff && (issue_addr_ff < count) && !hit;
   assign drained = (issue_addr_ff >= count) && !v1_ff && !v2_ff && !v3_ff;
   assign done    = scanning_ff && (hit || drained);

   assign dz     = DZ_W'(zt) - DZ_W'(rd_data);
   assign adz_in = ADZ_W'(dz[DZ_W-1] ? -dz : dz);

   always_comb begin
      scanning_in   = scanning_ff;
      issue_addr_in = issue_addr_ff;
      if (start) begin
         scanning_in   = 1'b1;
         issue_addr_in = '0;
      end else begin
         if (done) begin
            scanning_in = 1'b0;
         end
         if (issue) begin
            issue_addr_in = issue_addr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff   <= 1'b0;
         issue_addr_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         scanning_ff   <= scanning_in;
         issue_addr_ff <= issue_addr_in;
         // a hit kills everything behind it
         v1_ff         <= issue;
         v2_ff         <= v1_ff && !hit;
         v3_ff         <= v2_ff && !hit;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff   <= issue_addr_ff[AW-1:0];
      idx2_ff   <= idx1_ff;
      idx3_ff   <= idx2_ff;
      adz2_ff   <= adz_in;
      prod3_ff  <= PROD_W'(adz2_ff) * PROD_W'(sine);
      lfail3_ff <= adz2_ff > ADZ_W'(long_cut);
   end

   assign rd_en     = issue;
   assign rd_addr   = issue_addr_ff[AW-1:0];
   assign stat.done = done;
   assign stat.hit  = hit;
   assign hit_index = idx3_ff;

endmodule

// ===== src/tvfm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_checker
// Port-level checks of the first-match block, bound to the top level.
// ---------------------------------------------------------------------------
module tvfm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input tvfm_pkg::req_data_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tvfm_pkg::rsp_data_type rsp_data
);

   // a pending result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> rsp_data.vertex_index == '0)
      else $error("unmatched result with nonzero vertex index");

   // a track occupies the block; table upkeep does not
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == tvfm_pkg::MODE_MATCH) |=> !req_ready)
      else $error("new item taken while a track is in flight");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode != tvfm_pkg::MODE_MATCH) |=> req_ready)
      else $error("block stalled after a table item");

endmodule

bind track_vertex_first_match_top tvfm_checker u_tvfm_checker (.*);

// ===== tb/tvfm_match_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvfm_match_checker
// Watches the req, rsp and csr ports of the first-match block. It keeps its
// own vertex table and cut registers, predicts the result of every accepted
// track and compares each returned result against the oldest prediction.
// ---------------------------------------------------------------------------
module tvfm_match_checker
   import tvfm_pkg::*;
#(
   parameter int MAX_VERTICES     = MAX_VERTICES_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_data_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output int                   error_count,
   output int                   awaited_count
);

   localparam real HALF_PI = 1.5707963267948966;

   logic signed [COORD_W-1:0] d0_cut;
   logic [CUT_W-1:0]          dz_cut;
   logic [CUT_W-1:0]          dz_sin_cut;
   logic signed [COORD_W-1:0] vtx_z [MAX_VERTICES];
   int                        vtx_fill;
   int unsigned               sine_q15 [SINE_TABLE_DEPTH+1];
   rsp_data_type              pending_matches [$];
   rsp_data_type              oldest;

   // quarter-wave sine in Q1.15, rounded half up and capped below 1.0
   initial begin
      real v;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         v = $floor(32768.0 * $sin(HALF_PI * k / SINE_TABLE_DEPTH) + 0.5);
         sine_q15[k] = (v > 32767.0) ? 32767 : int'(v);
      end
   end

   function automatic rsp_data_type associate_track(input req_data_type trk);
      rsp_data_type res;
      longint       zt;
      longint       dz;
      longint       adz;
      longint       s;
      int unsigned  a;
      int unsigned  k;
      bit           found;
      res   = '0;
      found = 1'b0;
      if ($signed(trk.track_d0) > d0_cut)
         return res;
      zt = longint'($signed(trk.track_z0)) + longint'($signed(trk.track_vz));
      a  = (trk.track_theta < 16'd32768) ? trk.track_theta : 65536 - trk.track_theta;
      k  = (a * SINE_TABLE_DEPTH + 16384) / 32768;
      if (k > SINE_TABLE_DEPTH)
         k = SINE_TABLE_DEPTH;
      s = longint'(sine_q15[k]);
      for (int i = 0; i < vtx_fill && !found; i++) begin
         dz  = zt - longint'(vtx_z[i]);
         adz = (dz < 0) ? -dz : dz;
         if (adz <= longint'(dz_cut) && adz * s <= (longint'(dz_sin_cut) << 15)) begin
            found            = 1'b1;
            res.matched      = 1'b1;
            res.vertex_index = INDEX_W'(i);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         d0_cut      = TRANSVERSE_CUT_RESET;
         dz_cut      = CUT_RESET;
         dz_sin_cut  = CUT_RESET;
         vtx_fill    = 0;
         error_count = 0;
         pending_matches.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TRANSVERSE_CUT: d0_cut = csr_wdata;
               CSR_LONG_CUT: dz_cut = csr_wdata[CUT_W-1:0];
               CSR_Z0SIN_CUT: dz_sin_cut = csr_wdata[CUT_W-1:0];
               default: ;
            endcase
         end
         // retire the older result first: an item taken on this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               $display("%0t: unexpected result matched=%0d vertex_index=%0d",
                        $time, rsp_data.matched, rsp_data.vertex_index);
               error_count++;
            end else begin
               oldest = pending_matches.pop_front();
               if (rsp_data.matched !== oldest.matched) begin
                  $display("%0t: matched expected %0d got %0d",
                           $time, oldest.matched, rsp_data.matched);
                  error_count++;
               end
               if (rsp_data.vertex_index !== oldest.vertex_index) begin
                  $display("%0t: vertex_index expected %0d got %0d",
                           $time, oldest.vertex_index, rsp_data.vertex_index);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_data.mode)
               MODE_CLEAR: vtx_fill = 0;
               MODE_APPEND: begin
                  if (vtx_fill < MAX_VERTICES) begin
                     vtx_z[vtx_fill] = req_data.vertex_z;
                     vtx_fill++;
                  end
               end
               MODE_MATCH: pending_matches.push_back(associate_track(req_data));
               default: ;
            endcase
         end
      end
      awaited_count = pending_matches.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the first-match block with a short directed list and then with
// random events (clear, a run of vertices, tracks aimed at stored vertices)
// under several cut settings, with random gaps, stalls and one long hold-off
// of the result side. Checking is done in tvfm_match_checker.
// ---------------------------------------------------------------------------
module tb_top;
   import tvfm_pkg::*;

   localparam logic [1:0]           MODE_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED     = 2'd3;
   localparam int                   N_PHASES       = 8;
   localparam int                   ITEMS_PER_PHASE = 156;
   localparam int                   HOLD_CYCLES    = 300;
   localparam int                   DRAIN_CYCLES   = MAX_VERTICES_DEF + 16;
   localparam int                   STALL_LIMIT    = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_data_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_data_type         rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;
   int                   error_count;
   int                   awaited_count;

   // stimulus-side view of the block, used to aim tracks and to repeat stored vertices
   int                   loaded_z [$];
   logic signed [COORD_W-1:0] tc_now;
   logic [CUT_W-1:0]     lc_now;
   int                   counted_items;
   int                   req_gap_pct;
   int                   rsp_stall_pct;
   bit                   rsp_hold;
   int                   quiet_cycles;

   track_vertex_first_match_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tvfm_match_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall bursts, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   function automatic req_data_type plain_item(input logic [1:0] mode);
      req_data_type it;
      it.mode        = mode;
      it.vertex_z    = COORD_W'($urandom);
      it.track_d0    = COORD_W'($urandom);
      it.track_z0    = COORD_W'($urandom);
      it.track_vz    = COORD_W'($urandom);
      it.track_theta = THETA_W'($urandom);
      return it;
   endfunction

   function automatic req_data_type vertex_item(input int z);
      req_data_type it;
      it          = plain_item(MODE_APPEND);
      it.vertex_z = COORD_W'(z);
      return it;
   endfunction

   function automatic req_data_type match_item(input int d0, input int z0, input int vz,
                                               input int theta);
      req_data_type it;
      it             = plain_item(MODE_MATCH);
      it.track_d0    = COORD_W'(d0);
      it.track_z0    = COORD_W'(z0);
      it.track_vz    = COORD_W'(vz);
      it.track_theta = THETA_W'(theta);
      return it;
   endfunction

   function automatic int pick_vertex(input int center);
      case ($urandom_range(0, 7))
         0: return int'($signed(COORD_W'($urandom)));
         1: return (loaded_z.size() != 0) ? loaded_z[$urandom_range(0, loaded_z.size() - 1)]
                                         : center;
         default: return center + int'($urandom_range(0, 6000)) - 3000;
      endcase
   endfunction

   // a track whose z mostly lands near a stored vertex, at a distance scaled to the cut
   function automatic req_data_type track_item();
      req_data_type it;
      int           target;
      int           span;
      int           z0;
      it = plain_item(MODE_MATCH);
      case ($urandom_range(0, 9))
         0: it.track_d0 = tc_now;
         1: it.track_d0 = tc_now + 24'sd1;
         2, 3: ;
         default: it.track_d0 = COORD_W'(int'($urandom_range(0, 2000)) - 1000);
      endcase
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 8))
            0: it.track_theta = 16'd0;
            1: it.track_theta = 16'd1;
            2: it.track_theta = 16'd15;
            3: it.track_theta = 16'd16;
            4: it.track_theta = 16'd16384;
            5: it.track_theta = 16'd32767;
            6: it.track_theta = 16'd32768;
            7: it.track_theta = 16'd32769;
            default: it.track_theta = 16'd65535;
         endcase
      end
      if (loaded_z.size() != 0 && $urandom_range(0, 5) != 0) begin
         span   = (lc_now > 23'd4000000) ? 4000000 : int'(lc_now) + 2;
         target = loaded_z[$urandom_range(0, loaded_z.size() - 1)]
                  + int'($urandom_range(0, 2 * span)) - span;
         z0     = target - int'($signed(it.track_vz));
         if (z0 > 8388607 || z0 < -8388608) begin
            it.track_vz = COORD_W'(target / 2);
            z0          = target - target / 2;
         end
         it.track_z0 = COORD_W'(z0);
      end
      return it;
   endfunction

   task automatic send_item(input req_data_type it);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      case (it.mode)
         MODE_CLEAR: loaded_z.delete();
         MODE_APPEND: begin
            if (loaded_z.size() < MAX_VERTICES_DEF)
               loaded_z.push_back(int'($signed(it.vertex_z)));
         end
         default: ;
      endcase
      if (it.mode != MODE_UNUSED)
         counted_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      // appends or clears may still be in flight after the last result
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_cuts(input logic signed [COORD_W-1:0] tc, input logic [CUT_W-1:0] lc,
                           input logic [CUT_W-1:0] zc, input bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= CSR_TRANSVERSE_CUT;
      csr_wdata <= tc;
      @(negedge clock);
      csr_index <= CSR_LONG_CUT;
      csr_wdata <= {1'($urandom), lc};
      @(negedge clock);
      csr_index <= CSR_Z0SIN_CUT;
      csr_wdata <= {1'($urandom), zc};
      @(negedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= COORD_W'($urandom);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      tc_now = tc;
      lc_now = lc;
   endtask

   // clear, a run of vertices, then tracks with some noise and broken events
   task automatic run_event(input int nv, input int nt);
      int center;
      center = int'($urandom_range(0, 2000000)) - 1000000;
      send_item(plain_item(MODE_CLEAR));
      repeat (nv) send_item(vertex_item(pick_vertex(center)));
      repeat (nt) begin
         case ($urandom_range(0, 39))
            0, 1: send_item(plain_item(MODE_UNUSED));
            2, 3: send_item(vertex_item(pick_vertex(center)));
            4: send_item(plain_item(MODE_CLEAR));
            default: send_item(track_item());
         endcase
      end
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   initial begin
      int                        phase_end;
      logic signed [COORD_W-1:0] tc;
      logic [CUT_W-1:0]          lc;
      logic [CUT_W-1:0]          zc;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_TRANSVERSE_CUT;
      csr_wdata     = '0;
      tc_now        = TRANSVERSE_CUT_RESET;
      lc_now        = CUT_RESET;
      counted_items = 0;
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      rsp_hold      = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, every mode, empty table, duplicates
      send_item(match_item(0, 0, 0, 0));
      send_item(plain_item(MODE_UNUSED));
      send_item(vertex_item(-8388608));
      send_item(vertex_item(8388607));
      send_item(vertex_item(0));
      send_item(vertex_item(1000));
      send_item(match_item(0, 8388607, 8388607, 32768));
      send_item(match_item(0, -8388608, -8388608, 65535));
      send_item(match_item(8388607, 0, 0, 0));
      send_item(match_item(-8388608, 600, 400, 16384));
      send_item(match_item(5, 1000, 0, 32767));
      send_item(match_item(-1, 12345, -12345, 1));
      send_item(plain_item(MODE_CLEAR));
      send_item(match_item(0, 1, 2, 100));
      send_item(vertex_item(5));
      send_item(vertex_item(5));
      send_item(match_item(0, 3, 2, 49152));
      send_item(plain_item(MODE_UNUSED));
      send_item(match_item(0, 5, 0, 16));

      for (int p = 0; p < N_PHASES; p++) begin
         if (p != 0) begin
            drain_results();
            case (p)
               1: set_cuts(24'sd0, 23'd1000, 23'd300, 1'b0);
               2: set_cuts(-24'sd8388608, 23'd8388607, 23'd0, 1'b0);
               3: set_cuts(24'sd8388607, 23'd0, 23'd8388607, 1'b1);
               4: begin
                  tc = COORD_W'(int'($urandom_range(0, 2000)) - 1000);
                  set_cuts(tc, CUT_W'($urandom_range(0, 5000)),
                           CUT_W'($urandom_range(0, 3000)), 1'b0);
               end
               5: set_cuts(COORD_W'($urandom), CUT_W'($urandom), CUT_W'($urandom), 1'b1);
               6: set_cuts(24'sd5000, 23'd200, 23'd50, 1'b0);
               default: begin
                  lc = CUT_W'($urandom_range(0, 20000));
                  zc = CUT_W'($urandom_range(0, 20000));
                  set_cuts(COORD_W'($urandom_range(0, 50000)), lc, zc, 1'b0);
               end
            endcase
         end
         req_gap_pct   = (p == N_PHASES - 1) ? 0 : pick_pct();
         rsp_stall_pct = (p == N_PHASES - 1) ? 0 : pick_pct();
         phase_end     = counted_items + ITEMS_PER_PHASE;
         if (p == 0)
            run_event(MAX_VERTICES_DEF + 2, 20);   // overfill the table
         if (p == 4) begin
            // result side holds off while tracks keep coming
            rsp_hold    = 1'b1;
            req_gap_pct = 0;
            run_event(6, 40);
            req_gap_pct = pick_pct();
         end
         while (counted_items < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               run_event($urandom_range(40, MAX_VERTICES_DEF + 6), $urandom_range(5, 20));
            else
               run_event($urandom_range(0, 12), $urandom_range(1, 16));
         end
      end

      drain_results();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
